// File: sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: indexed list store shared definitions
// Sizes, opcodes and the command and status types that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY     = 64;
    localparam int ELEMENT_BITS = 32;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int FPOS_W   = 6;
    localparam int ENTRY_W  = 7;

    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS   = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = OPCODE_W'(0),
        OP_APPEND = OPCODE_W'(1),
        OP_GET    = OPCODE_W'(2),
        OP_SEARCH = OPCODE_W'(3),
        OP_REMOVE = OPCODE_W'(4),
        OP_CLEAR  = OPCODE_W'(5)
    } op_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT_M1,
        PTR_POS_P1,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_at_pos;
        logic    shift;
        ptr_op_t ptr_op;
        logic    wr_word;
        cnt_op_t cnt_op;
        logic    set_ok;
        logic    cap_rv;
        logic    cap_fp;
        logic    out_load;
    } ils_cmd_t;

    typedef struct packed {
        op_t  op;
        logic ins_ok;
        logic acc_ok;
        logic ptr_eq_pos;
        logic ptr_eq_count;
        logic hit;
    } ils_status_t;

endpackage

// File: sv/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath: indexed list store datapath
// Entry memory, entry count, scan pointer, request and result registers.
// ----------------------------------------------------------------------------
module ils_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ils_pkg::ils_cmd_t                   cmd,
    output ils_pkg::ils_status_t                status,
    input  logic [ils_pkg::OPCODE_W-1:0]        opcode,
    input  logic [ils_pkg::POS_W-1:0]           position,
    input  logic [ils_pkg::VALUE_W-1:0]         value,
    output logic                                ok,
    output logic [ils_pkg::VALUE_W-1:0]         read_value,
    output logic [ils_pkg::FPOS_W-1:0]          found_position,
    output logic [ils_pkg::ENTRY_W-1:0]         entry_count
);

    logic [ils_pkg::ELEMENT_BITS-1:0] entries_reg [ils_pkg::CAPACITY];

    ils_pkg::op_t                     op_reg;
    logic [ils_pkg::CMP_BITS-1:0]     pos_reg;
    logic [ils_pkg::ELEMENT_BITS-1:0] word_reg;
    logic [ils_pkg::COUNT_BITS-1:0]   count_reg;
    logic [ils_pkg::COUNT_BITS-1:0]   count_next;
    logic [ils_pkg::COUNT_BITS-1:0]   ptr_reg;
    logic [ils_pkg::COUNT_BITS-1:0]   ptr_next;
    logic [ils_pkg::ELEMENT_BITS-1:0] rdata_reg;
    logic [ils_pkg::ADDR_BITS-1:0]    rd_addr_reg;
    logic                             rd_valid_reg;
    logic                             shift_pend_reg;

    logic                             ok_w_reg;
    logic [ils_pkg::ELEMENT_BITS-1:0] rv_w_reg;
    logic [ils_pkg::ADDR_BITS-1:0]    fp_w_reg;

    logic                             ok_reg;
    logic [ils_pkg::VALUE_W-1:0]      read_value_reg;
    logic [ils_pkg::FPOS_W-1:0]       found_position_reg;
    logic [ils_pkg::ENTRY_W-1:0]      entry_count_reg;

    logic [ils_pkg::ADDR_BITS-1:0]    pos_addr;
    logic [ils_pkg::ADDR_BITS-1:0]    rd_addr;
    logic [ils_pkg::ADDR_BITS-1:0]    wr_addr;
    logic [ils_pkg::ELEMENT_BITS-1:0] wr_data;
    logic                             wr_en;
    logic [ils_pkg::CMP_BITS-1:0]     count_ext;
    ils_pkg::op_t                     op_in;

    assign op_in     = ils_pkg::op_t'(opcode);
    assign count_ext = ils_pkg::CMP_BITS'(count_reg);
    assign pos_addr  = pos_reg[ils_pkg::ADDR_BITS-1:0];
    assign rd_addr   = cmd.rd_at_pos ? pos_addr : ptr_reg[ils_pkg::ADDR_BITS-1:0];

    // shifted entry goes one place up for insert, one place down for remove
    always_comb
    begin
        wr_en   = cmd.wr_word | shift_pend_reg;
        wr_data = cmd.wr_word ? word_reg : rdata_reg;
        if (cmd.wr_word)
        begin
            wr_addr = pos_addr;
        end
        else if (op_reg == ils_pkg::OP_REMOVE)
        begin
            wr_addr = rd_addr_reg - ils_pkg::ADDR_BITS'(1);
        end
        else
        begin
            wr_addr = rd_addr_reg + ils_pkg::ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= entries_reg[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.ptr_op)
            ils_pkg::PTR_ZERO:     ptr_next = '0;
            ils_pkg::PTR_COUNT_M1: ptr_next = count_reg - ils_pkg::COUNT_BITS'(1);
            ils_pkg::PTR_POS_P1:   ptr_next = ils_pkg::COUNT_BITS'(pos_reg)
                                              + ils_pkg::COUNT_BITS'(1);
            ils_pkg::PTR_INC:      ptr_next = ptr_reg + ils_pkg::COUNT_BITS'(1);
            ils_pkg::PTR_DEC:      ptr_next = ptr_reg - ils_pkg::COUNT_BITS'(1);
            default:               ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            ils_pkg::CNT_INC: count_next = count_reg + ils_pkg::COUNT_BITS'(1);
            ils_pkg::CNT_DEC: count_next = count_reg - ils_pkg::COUNT_BITS'(1);
            ils_pkg::CNT_CLR: count_next = '0;
            default:          count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            shift_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            rd_valid_reg   <= cmd.rd_en;
            shift_pend_reg <= cmd.rd_en & cmd.shift;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            op_reg   <= op_in;
            word_reg <= ils_pkg::ELEMENT_BITS'(value);
            pos_reg  <= (op_in == ils_pkg::OP_APPEND) ? count_ext
                                                      : ils_pkg::CMP_BITS'(position);
            ok_w_reg <= 1'b0;
            rv_w_reg <= '0;
            fp_w_reg <= '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_w_reg <= 1'b1;
            end
            if (cmd.cap_rv)
            begin
                rv_w_reg <= rdata_reg;
            end
            if (cmd.cap_fp)
            begin
                fp_w_reg <= rd_addr_reg;
            end
        end
        if (cmd.out_load)
        begin
            ok_reg             <= ok_w_reg;
            read_value_reg     <= ils_pkg::VALUE_W'(rv_w_reg);
            found_position_reg <= ils_pkg::FPOS_W'(fp_w_reg);
            entry_count_reg    <= ils_pkg::ENTRY_W'(count_reg);
        end
    end

    assign status.op           = op_reg;
    assign status.ins_ok       = (count_reg < ils_pkg::COUNT_BITS'(ils_pkg::CAPACITY))
                                 && (pos_reg <= count_ext);
    assign status.acc_ok       = pos_reg < count_ext;
    assign status.ptr_eq_pos   = ils_pkg::CMP_BITS'(ptr_reg) == pos_reg;
    assign status.ptr_eq_count = ptr_reg == count_reg;
    assign status.hit          = rd_valid_reg && (rdata_reg == word_reg);

    assign ok             = ok_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;

endmodule

// File: sv/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl: indexed list store controller
// Sequences decode, memory walks and result delivery for one transaction.
// ----------------------------------------------------------------------------
module ils_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ils_pkg::ils_status_t status,
    output ils_pkg::ils_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET,
        S_SEARCH,
        S_SHIFT_UP,
        S_REM_CAP,
        S_SHIFT_DN,
        S_DRAIN,
        S_WRITE_NEW,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.ptr_op     = ils_pkg::PTR_HOLD;
        cmd.cnt_op     = ils_pkg::CNT_HOLD;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.op)
                    ils_pkg::OP_INSERT, ils_pkg::OP_APPEND:
                    begin
                        if (!status.ins_ok)
                        begin
                            state_next = S_DONE;
                        end
                        else if (status.acc_ok)
                        begin
                            cmd.ptr_op = ils_pkg::PTR_COUNT_M1;
                            state_next = S_SHIFT_UP;
                        end
                        else
                        begin
                            state_next = S_WRITE_NEW;
                        end
                    end
                    ils_pkg::OP_GET:
                    begin
                        if (status.acc_ok)
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_at_pos = 1'b1;
                            state_next    = S_GET;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ils_pkg::OP_SEARCH:
                    begin
                        cmd.ptr_op = ils_pkg::PTR_ZERO;
                        state_next = S_SEARCH;
                    end
                    ils_pkg::OP_REMOVE:
                    begin
                        if (status.acc_ok)
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_at_pos = 1'b1;
                            state_next    = S_REM_CAP;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ils_pkg::OP_CLEAR:
                    begin
                        cmd.cnt_op = ils_pkg::CNT_CLR;
                        cmd.set_ok = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_GET:
            begin
                cmd.cap_rv = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (status.hit)
                begin
                    cmd.cap_fp = 1'b1;
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.ptr_eq_count)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.ptr_op = ils_pkg::PTR_INC;
                end
            end
            S_SHIFT_UP:
            begin
                cmd.rd_en = 1'b1;
                cmd.shift = 1'b1;
                if (status.ptr_eq_pos)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.ptr_op = ils_pkg::PTR_DEC;
                end
            end
            S_REM_CAP:
            begin
                cmd.cap_rv = 1'b1;
                cmd.ptr_op = ils_pkg::PTR_POS_P1;
                state_next = S_SHIFT_DN;
            end
            S_SHIFT_DN:
            begin
                if (status.ptr_eq_count)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.shift  = 1'b1;
                    cmd.ptr_op = ils_pkg::PTR_INC;
                end
            end
            S_DRAIN:
            begin
                if (status.op == ils_pkg::OP_REMOVE)
                begin
                    cmd.cnt_op = ils_pkg::CNT_DEC;
                    cmd.set_ok = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WRITE_NEW;
                end
            end
            S_WRITE_NEW:
            begin
                cmd.wr_word = 1'b1;
                cmd.cnt_op  = ils_pkg::CNT_INC;
                cmd.set_ok  = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// File: sv/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: ordered word list with insert, remove and search
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. Insert and
// remove walk the entries from the position to the end of the list, and
// search walks the entries until a hit or the end, so the longest work is
// the walk over the entry memory, which has one read and one write port
// with registered read data and moves or compares one entry per cycle. The
// result sits in an output register, so the next transaction is accepted
// while a result still waits to be taken.
module indexed_list_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ils_pkg::OPCODE_W-1:0] opcode,
    input  logic [ils_pkg::POS_W-1:0]    position,
    input  logic [ils_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [ils_pkg::VALUE_W-1:0]  read_value,
    output logic [ils_pkg::FPOS_W-1:0]   found_position,
    output logic [ils_pkg::ENTRY_W-1:0]  entry_count
);

    ils_pkg::ils_cmd_t    cmd;
    ils_pkg::ils_status_t status;

    ils_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ils_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

endmodule
